[sv/tgpw_pkg.sv]
// Package of the text glyph page writer: shared types, codes and the 5x8 font table.
// Used by the request/write interfaces' users, the front, queue, back and top modules.
package tgpw_pkg;

  localparam int GLYPH_COLS    = 5;
  localparam int FONT_CHARS    = 95;
  localparam int FIFO_DEPTH    = 2;
  localparam int APB_ADDR_W    = 4;

  localparam logic [2:0] LAST_COL = 3'd5;

  localparam logic [7:0] CHAR_FIRST = 8'h20;
  localparam logic [7:0] CHAR_LAST  = 8'h7E;
  localparam logic [7:0] CHAR_SUBST = 8'h3F;

  localparam logic OP_DRAW       = 1'b0;
  localparam logic OP_SET_CURSOR = 1'b1;

  localparam logic [1:0] REG_COLUMN_OFFSET  = 2'd0;
  localparam logic [1:0] REG_TOP_BIT_IS_LSB = 2'd1;
  localparam logic [1:0] REG_INK_ON         = 2'd2;

  typedef struct packed {
    logic [2:0] column_offset;
    logic       top_bit_is_lsb;
    logic       ink_on;
  } cfg_t;

  typedef struct packed {
    logic signed [9:0]  cx;
    logic [2:0]         page;
    logic [2:0]         shift;
    logic [7:0]         mask_lo;
    logic [7:0]         mask_hi;
    logic [4:0][7:0]    cols;
  } job_t;

  function automatic logic signed [11:0] sx12(input logic signed [9:0] v);
    return $signed({{2{v[9]}}, v});
  endfunction

  function automatic logic signed [9:0] sat10(input logic signed [11:0] v);
    logic signed [9:0] r;
    if (v > 12'sd511) begin
      r = 10'sd511;
    end else if (v < -12'sd512) begin
      r = -10'sd512;
    end else begin
      r = v[9:0];
    end
    return r;
  endfunction

  localparam logic [7:0] FONT_ROM [FONT_CHARS][GLYPH_COLS] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h5F, 8'h00, 8'h00},
    '{8'h00, 8'h07, 8'h00, 8'h07, 8'h00},
    '{8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14},
    '{8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12},
    '{8'h23, 8'h13, 8'h08, 8'h64, 8'h62},
    '{8'h36, 8'h49, 8'h55, 8'h22, 8'h50},
    '{8'h00, 8'h05, 8'h03, 8'h00, 8'h00},
    '{8'h00, 8'h1C, 8'h22, 8'h41, 8'h00},
    '{8'h00, 8'h41, 8'h22, 8'h1C, 8'h00},
    '{8'h14, 8'h08, 8'h3E, 8'h08, 8'h14},
    '{8'h08, 8'h08, 8'h3E, 8'h08, 8'h08},
    '{8'h00, 8'h50, 8'h30, 8'h00, 8'h00},
    '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
    '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00},
    '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02},
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
    '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46},
    '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
    '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30},
    '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
    '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00},
    '{8'h00, 8'h56, 8'h36, 8'h00, 8'h00},
    '{8'h08, 8'h14, 8'h22, 8'h41, 8'h00},
    '{8'h14, 8'h14, 8'h14, 8'h14, 8'h14},
    '{8'h00, 8'h41, 8'h22, 8'h14, 8'h08},
    '{8'h02, 8'h01, 8'h51, 8'h09, 8'h06},
    '{8'h32, 8'h49, 8'h79, 8'h41, 8'h3E},
    '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22},
    '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41},
    '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A},
    '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00},
    '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41},
    '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F},
    '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E},
    '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E},
    '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31},
    '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F},
    '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    '{8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F},
    '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h03, 8'h04, 8'h78, 8'h04, 8'h03},
    '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
    '{8'h00, 8'h7F, 8'h41, 8'h41, 8'h00},
    '{8'h02, 8'h04, 8'h08, 8'h10, 8'h20},
    '{8'h00, 8'h41, 8'h41, 8'h7F, 8'h00},
    '{8'h04, 8'h02, 8'h01, 8'h02, 8'h04},
    '{8'h40, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h00, 8'h01, 8'h02, 8'h00, 8'h00},
    '{8'h20, 8'h54, 8'h54, 8'h54, 8'h78},
    '{8'h7F, 8'h48, 8'h44, 8'h44, 8'h38},
    '{8'h38, 8'h44, 8'h44, 8'h44, 8'h20},
    '{8'h38, 8'h44, 8'h44, 8'h48, 8'h7F},
    '{8'h38, 8'h54, 8'h54, 8'h54, 8'h18},
    '{8'h08, 8'h7E, 8'h09, 8'h01, 8'h02},
    '{8'h08, 8'h54, 8'h54, 8'h54, 8'h3C},
    '{8'h7F, 8'h08, 8'h04, 8'h04, 8'h78},
    '{8'h00, 8'h44, 8'h7D, 8'h40, 8'h00},
    '{8'h20, 8'h40, 8'h44, 8'h3D, 8'h00},
    '{8'h7F, 8'h10, 8'h28, 8'h44, 8'h00},
    '{8'h00, 8'h41, 8'h7F, 8'h40, 8'h00},
    '{8'h7C, 8'h04, 8'h18, 8'h04, 8'h78},
    '{8'h7C, 8'h08, 8'h04, 8'h04, 8'h78},
    '{8'h38, 8'h44, 8'h44, 8'h44, 8'h38},
    '{8'h7C, 8'h14, 8'h14, 8'h14, 8'h08},
    '{8'h08, 8'h14, 8'h14, 8'h18, 8'h7C},
    '{8'h7C, 8'h08, 8'h04, 8'h04, 8'h08},
    '{8'h48, 8'h54, 8'h54, 8'h54, 8'h20},
    '{8'h04, 8'h3F, 8'h44, 8'h40, 8'h20},
    '{8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C},
    '{8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C},
    '{8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C},
    '{8'h44, 8'h28, 8'h10, 8'h28, 8'h44},
    '{8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C},
    '{8'h44, 8'h64, 8'h54, 8'h4C, 8'h44},
    '{8'h00, 8'h08, 8'h36, 8'h41, 8'h00},
    '{8'h00, 8'h00, 8'h7F, 8'h00, 8'h00},
    '{8'h00, 8'h41, 8'h36, 8'h08, 8'h00},
    '{8'h10, 8'h08, 8'h08, 8'h10, 8'h08}
  };

endpackage

[sv/tgpw_req_if.sv]
// Request channel of the text glyph page writer: draw-character or set-cursor requests.
// Valid/ready handshake; no package dependency.
interface tgpw_req_if;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [7:0]        char_code;
  logic signed [9:0] new_x;
  logic signed [9:0] new_y;

  modport source (output valid, opcode, char_code, new_x, new_y, input ready);
  modport sink   (input valid, opcode, char_code, new_x, new_y, output ready);
endinterface

[sv/tgpw_wr_if.sv]
// Write channel of the text glyph page writer: one masked frame buffer byte per request.
// Valid/ready handshake; no package dependency.
interface tgpw_wr_if;
  logic       valid;
  logic       ready;
  logic [2:0] page;
  logic [7:0] column;
  logic [7:0] bits;
  logic [7:0] bit_mask;
  logic       last;

  modport source (output valid, page, column, bits, bit_mask, last, input ready);
  modport sink   (input valid, page, column, bits, bit_mask, last, output ready);
endinterface

[sv/tgpw_front.sv]
// Front part: accepts requests, keeps the cursor, wraps/drops and builds a glyph job.
// Depends on tgpw_pkg and tgpw_req_if.
module tgpw_front
  import tgpw_pkg::*;
#(
  parameter int VISIBLE_WIDTH  = 128,
  parameter int VISIBLE_HEIGHT = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tgpw_req_if.sink   req,
  input  cfg_t       cfg_i,
  input  logic       full_i,
  output logic       push_o,
  output job_t       job_o
);

  localparam logic signed [11:0] VW_S = 12'(VISIBLE_WIDTH);
  localparam logic signed [11:0] VH_S = 12'(VISIBLE_HEIGHT);

  logic signed [9:0]  cx_q, cx_d, cy_q, cy_d;
  logic signed [9:0]  cxw, cyw;
  logic               wrap, drop, accept;
  logic [7:0]         code;
  logic [6:0]         glyph_idx;
  logic signed [11:0] base;
  logic [2:0]         shift;
  logic [7:0]         mask_lo, mask_hi;
  logic [4:0][7:0]    cols;

  assign req.ready = !full_i;
  assign accept    = req.valid && req.ready;

  always_comb begin
    wrap  = (sx12(cx_q) + 12'sd6) > VW_S;
    cxw   = wrap ? 10'sd0 : cx_q;
    cyw   = wrap ? sat10(sx12(cy_q) + 12'sd8) : cy_q;
    drop  = (sx12(cyw) + 12'sd8) > VH_S;
    shift = cyw[2:0];
    base  = sx12({cyw[9:3], 3'b000});
  end

  always_comb begin
    code      = (req.char_code inside {[CHAR_FIRST:CHAR_LAST]}) ? req.char_code : CHAR_SUBST;
    glyph_idx = 7'(code - CHAR_FIRST);
  end

  always_comb begin
    logic [7:0] g;
    logic [7:0] o;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      g = FONT_ROM[glyph_idx][c];
      for (int b = 0; b < 8; b++) begin
        o[b] = g[7 - b];
      end
      if (cfg_i.top_bit_is_lsb) begin
        o = g;
      end
      cols[c] = cfg_i.ink_on ? o : 8'h00;
    end
  end

  always_comb begin
    logic signed [11:0] y0;
    logic signed [11:0] y1;
    for (int b = 0; b < 8; b++) begin
      y0 = base + 12'(b);
      y1 = y0 + 12'sd8;
      mask_lo[b] = (3'(b) >= shift) && (y0 >= 12'sd0) && (y0 < VH_S);
      mask_hi[b] = (3'(b) < shift) && (y1 >= 12'sd0) && (y1 < VH_S);
    end
  end

  always_comb begin
    job_o.cx      = cxw;
    job_o.page    = cyw[5:3];
    job_o.shift   = shift;
    job_o.mask_lo = mask_lo;
    job_o.mask_hi = mask_hi;
    job_o.cols    = cols;
  end

  assign push_o = accept && (req.opcode == OP_DRAW) && !drop && ((mask_lo | mask_hi) != 8'h00);

  always_comb begin
    cx_d = cx_q;
    cy_d = cy_q;
    if (accept) begin
      if (req.opcode == OP_SET_CURSOR) begin
        cx_d = req.new_x;
        cy_d = req.new_y;
      end else begin
        cy_d = cyw;
        cx_d = drop ? cxw : sat10(sx12(cxw) + 12'sd6);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
    end else begin
      cx_q <= cx_d;
      cy_q <= cy_d;
    end
  end

endmodule

[sv/tgpw_fifo.sv]
// Short job queue between the front and back parts of the glyph page writer.
// Depends on tgpw_pkg (job_t, FIFO_DEPTH).
module tgpw_fifo
  import tgpw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  job_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

endmodule

[sv/tgpw_back.sv]
// Back part: steps a glyph job column by column and page by page into masked writes.
// Depends on tgpw_pkg and tgpw_wr_if.
module tgpw_back
  import tgpw_pkg::*;
#(
  parameter int VISIBLE_WIDTH  = 128,
  parameter int PHYSICAL_WIDTH = 132
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  logic       empty_i,
  output logic       pop_o,
  input  logic [2:0] column_offset_i,
  tgpw_wr_if.source  wr
);

  localparam logic signed [11:0] VW_S = 12'(VISIBLE_WIDTH);
  localparam logic signed [11:0] PW_S = 12'(PHYSICAL_WIDTH);

  logic [2:0]         col_q, col_d;
  logic               hi_q, hi_d;
  logic               step, emit, is_last, go_hi, col_ok, nxt_ok;
  logic signed [11:0] off, x_cur, x_nxt, phys;
  logic [7:0]         pat, mask, bits;
  logic [15:0]        sh;

  logic       valid_q;
  logic [2:0] page_q;
  logic [7:0] column_q, bits_q, mask_q;
  logic       last_q;

  always_comb begin
    off    = $signed({9'd0, column_offset_i});
    x_cur  = sx12(job_i.cx) + $signed({9'd0, col_q});
    x_nxt  = x_cur + 12'sd1;
    phys   = x_cur + off;
    col_ok = (x_cur >= 12'sd0) && (x_cur < VW_S) && (phys < PW_S);
    nxt_ok = (x_nxt >= 12'sd0) && (x_nxt < VW_S) && ((x_nxt + off) < PW_S);
    pat    = (col_q < LAST_COL) ? job_i.cols[col_q] : 8'h00;
    sh     = {8'h00, pat} << job_i.shift;
    mask   = hi_q ? job_i.mask_hi : job_i.mask_lo;
    bits   = hi_q ? (sh[15:8] & job_i.mask_hi) : (sh[7:0] & job_i.mask_lo);
    emit   = col_ok && (mask != 8'h00);
    is_last = col_ok && ((col_q == LAST_COL) || !nxt_ok)
              && (hi_q || (job_i.mask_hi == 8'h00));
  end

  assign step  = !empty_i && (!valid_q || wr.ready);
  assign go_hi = !hi_q && (job_i.mask_hi != 8'h00);
  assign pop_o = step && !go_hi && (col_q == LAST_COL);

  always_comb begin
    col_d = col_q;
    hi_d  = hi_q;
    if (step) begin
      if (go_hi) begin
        hi_d = 1'b1;
      end else begin
        hi_d  = 1'b0;
        col_d = (col_q == LAST_COL) ? 3'd0 : col_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      hi_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      hi_q  <= hi_d;
      if (step && emit) begin
        valid_q <= 1'b1;
      end else if (wr.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      page_q   <= hi_q ? job_i.page + 3'd1 : job_i.page;
      column_q <= phys[7:0];
      bits_q   <= bits;
      mask_q   <= mask;
      last_q   <= is_last;
    end
  end

  assign wr.valid    = valid_q;
  assign wr.page     = page_q;
  assign wr.column   = column_q;
  assign wr.bits     = bits_q;
  assign wr.bit_mask = mask_q;
  assign wr.last     = last_q;

endmodule

[sv/text_glyph_page_writer_unit.sv]
// Text glyph page writer: draws 5x8 font characters as masked page writes of a
// monochrome frame buffer. Holds the APB register file and ties front, queue and back.
// Depends on tgpw_pkg, tgpw_req_if, tgpw_wr_if, tgpw_front, tgpw_fifo, tgpw_back.
//
// Usage:
//   req_i carries one request per handshake: set cursor (opcode 1) or draw a character
//   (opcode 0). wr_o carries masked byte writes {page, column, bits, bit_mask, last}, in
//   column order with the lower page first; last marks the final write of a character.
//   Registers (APB, byte address 4*index): column_offset, top_bit_is_lsb, ink_on;
//   write them only while no request is in flight.
//   With the back part idle, a request goes through the job queue and the back part's
//   output register before its first write is valid; leading steps that write nothing
//   delay it further. Throughput: one back step per cycle while wr_o is free, one per
//   glyph column and per page a character's rows touch. Cursor loads, dropped characters
//   and characters clipped off in every row are handled at the front and queue no job;
//   a character clipped off in every column still takes its steps.
//   A two-entry job queue lets requests keep arriving while writes are produced.
//   Reset clears the cursor to (0,0), sets column_offset 0, top_bit_is_lsb 1, ink_on 1.
//   A stall on wr_o holds the output register and backs up the queue; req_i.ready
//   drops only when the queue is full.
module text_glyph_page_writer_unit
  import tgpw_pkg::*;
#(
  parameter int VISIBLE_WIDTH  = 128,
  parameter int VISIBLE_HEIGHT = 64,
  parameter int PHYSICAL_WIDTH = 132
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tgpw_req_if.sink              req_i,
  tgpw_wr_if.source             wr_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int OFFSET_LIM = (PHYSICAL_WIDTH > VISIBLE_WIDTH) ?
                              (PHYSICAL_WIDTH - VISIBLE_WIDTH) : 0;

  cfg_t       cfg_q, cfg_d;
  logic [1:0] reg_idx;
  logic       reg_wr;
  logic [2:0] off_wr;
  logic       push, full, pop, empty;
  job_t       job_in, job_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    off_wr = pwdata[2:0];
    if (32'(pwdata[2:0]) > OFFSET_LIM) begin
      off_wr = 3'(OFFSET_LIM);
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (reg_wr) begin
      case (reg_idx)
        REG_COLUMN_OFFSET:  cfg_d.column_offset  = off_wr;
        REG_TOP_BIT_IS_LSB: cfg_d.top_bit_is_lsb = pwdata[0];
        REG_INK_ON:         cfg_d.ink_on         = pwdata[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COLUMN_OFFSET:  prdata = {29'd0, cfg_q.column_offset};
      REG_TOP_BIT_IS_LSB: prdata = {31'd0, cfg_q.top_bit_is_lsb};
      REG_INK_ON:         prdata = {31'd0, cfg_q.ink_on};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.column_offset  <= 3'd0;
      cfg_q.top_bit_is_lsb <= 1'b1;
      cfg_q.ink_on         <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tgpw_front #(
    .VISIBLE_WIDTH  (VISIBLE_WIDTH),
    .VISIBLE_HEIGHT (VISIBLE_HEIGHT)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_i),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  tgpw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (job_out)
  );

  tgpw_back #(
    .VISIBLE_WIDTH  (VISIBLE_WIDTH),
    .PHYSICAL_WIDTH (PHYSICAL_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_i           (job_out),
    .empty_i         (empty),
    .pop_o           (pop),
    .column_offset_i (cfg_q.column_offset),
    .wr              (wr_o)
  );

  a_mask_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.valid |-> (wr_o.bit_mask != 8'h00))
    else $error("write request with empty mask");

  a_bits_in_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.valid |-> ((wr_o.bits & ~wr_o.bit_mask) == 8'h00))
    else $error("write bits outside mask");

  a_column_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.valid |-> (int'(wr_o.column) < PHYSICAL_WIDTH))
    else $error("write column beyond physical width");

  a_offset_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cfg_q.column_offset) <= OFFSET_LIM)
    else $error("column offset above clamp limit");

endmodule

[bench/testbench.sv]
// Self-checking bench for text_glyph_page_writer_unit: drives draw and cursor requests,
// predicts every masked page write from its own font table and cursor or a pinned row value, checks the writes.
// Depends on tgpw_pkg, tgpw_req_if, tgpw_wr_if and the RTL of the unit.
module testbench
  import tgpw_pkg::*;
();

  localparam int VIS_W         = 128;
  localparam int VIS_H         = 64;
  localparam int PHYS_W        = 132;
  localparam int GLYPH_ADVANCE = 6;
  localparam int GLYPH_ROWS    = 8;
  localparam int MAX_WRITES    = 12;
  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int DRAIN_CYCLES  = 24;
  localparam int LONG_HOLD     = 300;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 82;
  localparam int LIMIT_CYCLES  = 400000;

  typedef struct packed {
    logic [2:0] page;
    logic [7:0] column;
    logic [7:0] bits;
    logic [7:0] bit_mask;
    logic       last;
  } wr_beat_t;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_chk_e;

  typedef struct packed {
    logic              op;
    logic [7:0]        ch;
    logic signed [9:0] nx;
    logic signed [9:0] ny;
    row_chk_e          chk;
    wr_beat_t          pinned;
  } stim_row_t;

  localparam wr_beat_t NO_PIN = '0;

  localparam stim_row_t DIRECTED_ROWS [26] = '{
    '{OP_DRAW,       8'h20, 10'sd0,    10'sd0,    CHK_MODEL, NO_PIN},
    '{OP_DRAW,       8'h7E, 10'sd0,    10'sd0,    CHK_MODEL, NO_PIN},
    '{OP_DRAW,       8'h00, 10'sd0,    10'sd0,    CHK_MODEL, NO_PIN},
    '{OP_DRAW,       8'hFF, 10'sd0,    10'sd0,    CHK_MODEL, NO_PIN},
    '{OP_DRAW,       8'h1F, 10'sd0,    10'sd0,    CHK_MODEL, NO_PIN},
    '{OP_DRAW,       8'h7F, 10'sd0,    10'sd0,    CHK_MODEL, NO_PIN},
    '{OP_SET_CURSOR, 8'hA5, -10'sd5,   10'sd0,    CHK_NONE,  NO_PIN},
    '{OP_DRAW,       8'h41, 10'sd0,    10'sd0,    CHK_ONE,
      '{3'd0, 8'd0, 8'h00, 8'hFF, 1'b1}},
    '{OP_SET_CURSOR, 8'h5A, -10'sd5,   -10'sd7,   CHK_NONE,  NO_PIN},
    '{OP_DRAW,       8'h41, 10'sd0,    10'sd0,    CHK_ONE,
      '{3'd0, 8'd0, 8'h00, 8'h01, 1'b1}},
    '{OP_SET_CURSOR, 8'h00, -10'sd6,   10'sd0,    CHK_NONE,  NO_PIN},
    '{OP_DRAW,       8'h57, 10'sd0,    10'sd0,    CHK_NONE,  NO_PIN},
    '{OP_DRAW,       8'h57, 10'sd0,    10'sd0,    CHK_MODEL, NO_PIN},
    '{OP_SET_CURSOR, 8'hFF, 10'sd511,  10'sd511,  CHK_NONE,  NO_PIN},
    '{OP_DRAW,       8'h58, 10'sd0,    10'sd0,    CHK_NONE,  NO_PIN},
    '{OP_SET_CURSOR, 8'h00, 10'sh200,  10'sh200,  CHK_NONE,  NO_PIN},
    '{OP_DRAW,       8'h5A, 10'sd0,    10'sd0,    CHK_NONE,  NO_PIN},
    '{OP_SET_CURSOR, 8'h42, 10'sd122,  10'sd56,   CHK_NONE,  NO_PIN},
    '{OP_DRAW,       8'h42, 10'sd0,    10'sd0,    CHK_MODEL, NO_PIN},
    '{OP_DRAW,       8'h43, 10'sd0,    10'sd0,    CHK_NONE,  NO_PIN},
    '{OP_SET_CURSOR, 8'h67, 10'sd123,  10'sd3,    CHK_NONE,  NO_PIN},
    '{OP_DRAW,       8'h67, 10'sd0,    10'sd0,    CHK_MODEL, NO_PIN},
    '{OP_SET_CURSOR, 8'h6A, 10'sd60,   -10'sd4,   CHK_NONE,  NO_PIN},
    '{OP_DRAW,       8'h6A, 10'sd0,    10'sd0,    CHK_MODEL, NO_PIN},
    '{OP_SET_CURSOR, 8'h40, 10'sd0,    10'sd57,   CHK_NONE,  NO_PIN},
    '{OP_DRAW,       8'h40, 10'sd0,    10'sd0,    CHK_NONE,  NO_PIN}
  };

  localparam int PHASE_OFFSET [PHASES] = '{3, 4, 7, 0, 5};
  localparam int PHASE_LSB    [PHASES] = '{1, 0, 1, 0, 1};
  localparam int PHASE_INK    [PHASES] = '{1, 1, 0, 0, 1};

  // columns 0..4 of each glyph, column 0 in the top byte
  localparam logic [39:0] GLYPH_FONT [95] = '{
    40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
    40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
    40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
    40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
    40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
    40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
    40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
    40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
    40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
    40'h7F_40_40_40_40, 40'h7F_02_04_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
    40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h7F_20_18_20_7F,
    40'h63_14_08_14_63, 40'h03_04_78_04_03, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
    40'h02_04_08_10_20, 40'h00_41_41_7F_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
    40'h00_01_02_00_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20,
    40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h08_54_54_54_3C,
    40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h7F_10_28_44_00,
    40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
    40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
    40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
    40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
    40'h00_00_7F_00_00, 40'h00_41_36_08_00, 40'h10_08_08_10_08
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  tgpw_req_if req_if ();
  tgpw_wr_if  wr_if ();

  text_glyph_page_writer_unit #(
    .VISIBLE_WIDTH  (VIS_W),
    .VISIBLE_HEIGHT (VIS_H),
    .PHYSICAL_WIDTH (PHYS_W)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_if),
    .wr_o    (wr_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  logic signed [9:0] cursor_x   = '0;
  logic signed [9:0] cursor_y   = '0;
  int                cfg_offset = 0;
  logic              cfg_lsb    = 1'b1;
  logic              cfg_ink    = 1'b1;

  wr_beat_t char_beats [MAX_WRITES];
  wr_beat_t pending_writes [$];

  int burst_left     = 0;
  int items_sent     = 0;
  int writes_seen    = 0;
  int mismatch_count = 0;
  int hold_asks      = 0;

  function automatic logic signed [9:0] clamp10(input int v);
    logic signed [9:0] r;
    if (v > 511) begin
      r = 10'sd511;
    end else if (v < -512) begin
      r = 10'sh200;
    end else begin
      r = 10'(v);
    end
    return r;
  endfunction

  // Update the cursor and fill char_beats with the writes of one request.
  function automatic int render_request(input logic op, input logic [7:0] ch,
                                        input logic signed [9:0] nx,
                                        input logic signed [9:0] ny);
    int n, c, r, p, x, phys, y;
    logic [7:0] code;
    logic [39:0] glyph;
    logic [7:0] pat;
    logic on;
    logic [7:0] pm [8];
    logic [7:0] pb [8];
    n = 0;
    if (op == OP_SET_CURSOR) begin
      cursor_x = nx;
      cursor_y = ny;
      return 0;
    end
    if (int'(cursor_x) + GLYPH_ADVANCE > VIS_W) begin
      cursor_x = '0;
      cursor_y = clamp10(int'(cursor_y) + GLYPH_ROWS);
    end
    if (int'(cursor_y) + GLYPH_ROWS > VIS_H) return 0;
    code = ch;
    if (code < CHAR_FIRST || code > CHAR_LAST) code = CHAR_SUBST;
    glyph = GLYPH_FONT[code - CHAR_FIRST];
    for (c = 0; c < GLYPH_ADVANCE; c++) begin
      x = int'(cursor_x) + c;
      phys = x + cfg_offset;
      if (x < 0 || x >= VIS_W || phys >= PHYS_W) continue;
      pat = (c < GLYPH_COLS) ? glyph[39 - 8 * c -: 8] : 8'h00;
      for (p = 0; p < 8; p++) begin
        pm[p] = 8'h00;
        pb[p] = 8'h00;
      end
      for (r = 0; r < GLYPH_ROWS; r++) begin
        y = int'(cursor_y) + r;
        if (y < 0 || y >= VIS_H) continue;
        on = cfg_lsb ? pat[r] : pat[7 - r];
        on = on & cfg_ink;
        pm[y / 8][y % 8] = 1'b1;
        if (on) pb[y / 8][y % 8] = 1'b1;
      end
      for (p = 0; p < 8; p++) begin
        if (pm[p] != 8'h00 && n < MAX_WRITES) begin
          char_beats[n] = '{page: 3'(p), column: 8'(phys), bits: pb[p], bit_mask: pm[p],
                            last: 1'b0};
          n++;
        end
      end
    end
    if (n > 0) char_beats[n - 1].last = 1'b1;
    cursor_x = clamp10(int'(cursor_x) + GLYPH_ADVANCE);
    return n;
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input int val);
    int v;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_COLUMN_OFFSET: begin
        v = val & 7;
        cfg_offset = (v > PHYS_W - VIS_W) ? ((PHYS_W > VIS_W) ? PHYS_W - VIS_W : 0) : v;
      end
      REG_TOP_BIT_IS_LSB: cfg_lsb = val[0];
      REG_INK_ON: cfg_ink = val[0];
      default: ;
    endcase
  endtask

  task automatic offer_request(input logic op, input logic [7:0] ch,
                               input logic signed [9:0] nx, input logic signed [9:0] ny,
                               input row_chk_e chk, input wr_beat_t pinned);
    int idle, n, k;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (idle > 0) begin
        req_if.valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    burst_left--;
    req_if.valid     <= 1'b1;
    req_if.opcode    <= op;
    req_if.char_code <= ch;
    req_if.new_x     <= nx;
    req_if.new_y     <= ny;
    do @(posedge clk); while (!req_if.ready);
    items_sent++;
    n = render_request(op, ch, nx, ny);
    case (chk)
      CHK_MODEL: for (k = 0; k < n; k++) pending_writes.push_back(char_beats[k]);
      CHK_ONE: pending_writes.push_back(pinned);
      default: ;
    endcase
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_requests(input int count);
    int i, pick, x, y;
    logic op;
    logic [7:0] ch;
    logic signed [9:0] nx, ny;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      op = OP_DRAW;
      ch = 8'($urandom_range(0, 255));
      nx = 10'($urandom);
      ny = 10'($urandom);
      if (pick < 6) begin
        op = OP_SET_CURSOR;
      end else if (pick < 22) begin
        op = OP_SET_CURSOR;
        x = int'($urandom_range(0, 138)) - 8;
        y = int'($urandom_range(0, 74)) - 10;
        nx = 10'(x);
        ny = 10'(y);
      end else if (pick < 88) begin
        ch = 8'($urandom_range(32, 126));
      end
      offer_request(op, ch, nx, ny, CHK_MODEL, NO_PIN);
    end
  endtask

  initial begin : write_sink
    int tick, hold_left, hold_seen;
    tick = 0;
    hold_left = 0;
    hold_seen = 0;
    wr_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_left > 0) begin
        wr_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
        wr_if.ready <= 1'b0;
      end else begin
        case ((tick / 64) % 4)
          0: wr_if.ready <= 1'b1;
          1: wr_if.ready <= tick[0];
          2: wr_if.ready <= ($urandom_range(0, 9) < 7);
          default: wr_if.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin : write_check
    wr_beat_t want;
    if (rst_n && wr_if.valid && wr_if.ready) begin
      writes_seen++;
      if (pending_writes.size() == 0) begin
        $error("unexpected page write: page %0d column %0d bits %h mask %h",
               wr_if.page, wr_if.column, wr_if.bits, wr_if.bit_mask);
        mismatch_count++;
      end else begin
        want = pending_writes.pop_front();
        if (wr_if.page != want.page) begin
          $error("page: expected %0d, got %0d", want.page, wr_if.page);
          mismatch_count++;
        end
        if (wr_if.column != want.column) begin
          $error("column: expected %0d, got %0d", want.column, wr_if.column);
          mismatch_count++;
        end
        if (wr_if.bits != want.bits) begin
          $error("bits: expected %h, got %h", want.bits, wr_if.bits);
          mismatch_count++;
        end
        if (wr_if.bit_mask != want.bit_mask) begin
          $error("bit_mask: expected %h, got %h", want.bit_mask, wr_if.bit_mask);
          mismatch_count++;
        end
        if (wr_if.last != want.last) begin
          $error("last: expected %0d, got %0d", want.last, wr_if.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : run_limit
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int i, ph, leftover;
    stim_row_t row;
    req_if.valid     <= 1'b0;
    req_if.opcode    <= OP_DRAW;
    req_if.char_code <= 8'h00;
    req_if.new_x     <= '0;
    req_if.new_y     <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    for (i = 0; i < $size(DIRECTED_ROWS); i++) begin
      row = DIRECTED_ROWS[i];
      offer_request(row.op, row.ch, row.nx, row.ny, row.chk, row.pinned);
    end
    settle();

    for (ph = 0; ph < PHASES; ph++) begin
      cfg_write(REG_COLUMN_OFFSET, PHASE_OFFSET[ph]);
      cfg_write(REG_TOP_BIT_IS_LSB, PHASE_LSB[ph]);
      cfg_write(REG_INK_ON, PHASE_INK[ph]);
      // stall the write side long enough to fill the job queue
      if (ph == 1) hold_asks <= hold_asks + 1;
      random_requests(PHASE_ITEMS);
      settle();
    end

    leftover = pending_writes.size();
    if (leftover != 0) $error("%0d expected page writes never arrived", leftover);
    $display("Sent %0d requests (%0d directed), checked %0d page writes",
             items_sent, $size(DIRECTED_ROWS), writes_seen);
    $display("Covered %0d register settings incl. offset clamp, both bit orders, ink off",
             PHASES + 1);
    if (mismatch_count == 0 && leftover == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[text_glyph_page_writer_unit.f]
sv/tgpw_pkg.sv
sv/tgpw_req_if.sv
sv/tgpw_wr_if.sv
sv/tgpw_front.sv
sv/tgpw_fifo.sv
sv/tgpw_back.sv
sv/text_glyph_page_writer_unit.sv
bench/testbench.sv
